[design/crt_pkg.sv]
// shared types, codes and defaults for the click region table
`default_nettype none
package crt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int COORD_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FIND   = 2'd1,
        OP_SCROLL = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_ON   = 2'd1,
        REQ_OFF  = 2'd2
    } mouse_req_t;

    localparam logic CFG_MOUSE_ENABLE  = 1'b0;
    localparam logic CFG_KEEP_MOUSE_ON = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] row_y;
        logic [7:0] col_lo;
        logic [7:0] col_hi;
        logic       hungry;
        logic [7:0] tag;
        logic [7:0] scroll_count;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [4:0] match_slot;
        logic [7:0] match_tag;
        logic       add_ok;
        logic [5:0] entries_left;
        logic [1:0] mouse_request;
    } out_item_t;

endpackage
`default_nettype wire

[design/crt_mem.sv]
// region storage: one write port, one registered read port
`default_nettype none
module crt_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 33
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[design/click_region_table.sv]
// click region table: top level with sequencer and scan datapath
// add, clear and operations that need no scan go straight from accept to the result
// stage; find and scroll scan the stored regions, one stored region read per cycle
// one transaction is in work at a time; the result register frees input side
// reset clears count, head pointer, control registers and state; region memory is not
// cleared, only entries below the count are ever read
`default_nettype none
module click_region_table #(
    parameter int TABLE_DEPTH = crt_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = crt_pkg::COORD_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire crt_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output crt_pkg::out_item_t      out_item
);
    import crt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int REG_W = 3 * COORD_BITS + 9;
    localparam int CMP_W = COORD_BITS + 8;
    localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] FULL_V = CNT_W'(TABLE_DEPTH);

    // configuration
    logic mouse_en_reg;
    logic keep_on_reg;

    // sequencer
    state_t state_reg, state_next;

    // table bookkeeping: circular buffer, logical slot 0 sits at head
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] head_reg;

    // latched transaction
    op_t                 op_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [7:0]          scnt_reg;

    // scan bookkeeping
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] keep_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pidx_reg;

    // per pass best candidate
    logic             f1_reg, f2_reg, f3_reg;
    logic [IDX_W-1:0] s1_reg, s2_reg, s3_reg;
    logic [7:0]       t1_reg, t2_reg, t3_reg;

    // result fields
    logic             found_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [7:0]       mtag_reg;
    logic             addok_reg;
    mouse_req_t       req_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg;

    // incoming fields in coordinate width
    logic [COORD_BITS-1:0] in_y, in_x, in_hi;
    logic                  accept;
    logic                  add_go;
    logic [IDX_W-1:0]      head_m1;

    // memory port signals
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [REG_W-1:0] mem_wdata, mem_rdata;

    // read data split
    logic [COORD_BITS-1:0] r_row, r_lo, r_hi;
    logic                  r_hung;
    logic [7:0]            r_tag;
    logic                  hit1, hit2, hit3, keep_hit;
    logic [CMP_W-1:0]      row_ext, cnt_ext;

    logic             rd_busy, scan_done, out_free;
    logic [IDX_W:0]   rsum, wsum;

    assign in_y  = COORD_BITS'(in_item.row_y);
    assign in_x  = COORD_BITS'(in_item.col_lo);
    assign in_hi = COORD_BITS'(in_item.col_hi);

    assign accept  = in_valid && !in_stall;
    assign add_go  = accept && (op_t'(in_item.mode) == OP_ADD) && mouse_en_reg
                     && (count_reg < FULL_V);
    assign head_m1 = (head_reg == '0) ? IDX_W'(TABLE_DEPTH - 1) : head_reg - 1'b1;

    assign rd_busy   = rd_idx_reg < count_reg;
    assign scan_done = (state_reg == ST_SCAN) && !rd_busy && !pend_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // logical to physical slot, sums stay below twice the depth
    assign rsum = {1'b0, head_reg} + {1'b0, rd_idx_reg[IDX_W-1:0]};
    assign wsum = {1'b0, head_reg} + {1'b0, keep_reg[IDX_W-1:0]};

    assign {r_row, r_lo, r_hi, r_hung, r_tag} = mem_rdata;

    assign hit1 = (r_row == y_reg) && (x_reg >= r_lo) && (x_reg <= r_hi);
    assign hit2 = r_hung && (r_row == y_reg) && (x_reg >= r_lo);
    assign hit3 = r_hung && (r_row == y_reg) && (x_reg <= r_lo);

    assign row_ext  = CMP_W'(r_row);
    assign cnt_ext  = CMP_W'(scnt_reg);
    assign keep_hit = row_ext >= cnt_ext;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((op_t'(in_item.mode) == OP_FIND && count_reg != '0) ||
                        (op_t'(in_item.mode) == OP_SCROLL && mouse_en_reg &&
                         count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and memory port
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        mem_re    = (state_reg == ST_SCAN) && rd_busy;
        mem_raddr = (rsum >= DEPTH_V) ? IDX_W'(rsum - DEPTH_V) : IDX_W'(rsum);
        mem_we    = 1'b0;
        mem_waddr = head_m1;
        mem_wdata = {in_y, in_x, in_hi, in_item.hungry, in_item.tag};
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_we = add_go;
            end
            ST_SCAN:
            begin
                // compaction writes behind the read pointer
                if (op_reg == OP_SCROLL && pend_reg && keep_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = (wsum >= DEPTH_V) ? IDX_W'(wsum - DEPTH_V)
                                                  : IDX_W'(wsum);
                    mem_wdata = {COORD_BITS'(row_ext - cnt_ext), r_lo, r_hi,
                                 r_hung, r_tag};
                end
            end
            ST_RESP:
            begin
                mem_we = 1'b0;
            end
            default: mem_we = 1'b0;
        endcase
    end

    crt_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (REG_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mouse_en_reg  <= 1'b0;
            keep_on_reg   <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_MOUSE_ENABLE)
                begin
                    mouse_en_reg <= cfg_data;
                end
                else
                begin
                    keep_on_reg <= cfg_data;
                end
            end
            pend_reg <= mem_re;
            if (add_go)
            begin
                head_reg  <= head_m1;
                count_reg <= count_reg + 1'b1;
            end
            if (accept && op_t'(in_item.mode) == OP_CLEAR && mouse_en_reg)
            begin
                count_reg <= '0;
            end
            if (scan_done && op_reg == OP_SCROLL)
            begin
                count_reg <= keep_reg;
            end
            if (state_reg == ST_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // transaction and scan datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(in_item.mode);
            y_reg      <= in_y;
            x_reg      <= in_x;
            scnt_reg   <= in_item.scroll_count;
            rd_idx_reg <= '0;
            keep_reg   <= '0;
            f1_reg     <= 1'b0;
            f2_reg     <= 1'b0;
            f3_reg     <= 1'b0;
            found_reg  <= 1'b0;
            slot_reg   <= '0;
            mtag_reg   <= '0;
            addok_reg  <= add_go;
            req_reg    <= add_go ? REQ_ON : REQ_NONE;
            if (op_t'(in_item.mode) == OP_CLEAR && mouse_en_reg && count_reg != '0
                && !keep_on_reg)
            begin
                req_reg <= REQ_OFF;
            end
        end
        if (mem_re)
        begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
            pidx_reg   <= rd_idx_reg[IDX_W-1:0];
        end
        if (state_reg == ST_SCAN && pend_reg)
        begin
            if (op_reg == OP_SCROLL)
            begin
                if (keep_hit)
                begin
                    keep_reg <= keep_reg + 1'b1;
                end
            end
            else
            begin
                // first exact, first hungry right of start, last hungry left
                if (hit1 && !f1_reg)
                begin
                    f1_reg <= 1'b1;
                    s1_reg <= pidx_reg;
                    t1_reg <= r_tag;
                end
                if (hit2 && !f2_reg)
                begin
                    f2_reg <= 1'b1;
                    s2_reg <= pidx_reg;
                    t2_reg <= r_tag;
                end
                if (hit3)
                begin
                    f3_reg <= 1'b1;
                    s3_reg <= pidx_reg;
                    t3_reg <= r_tag;
                end
            end
        end
        if (scan_done && op_reg == OP_FIND)
        begin
            found_reg <= f1_reg || f2_reg || f3_reg;
            if (f1_reg)
            begin
                slot_reg <= s1_reg;
                mtag_reg <= t1_reg;
            end
            else if (f2_reg)
            begin
                slot_reg <= s2_reg;
                mtag_reg <= t2_reg;
            end
            else if (f3_reg)
            begin
                slot_reg <= s3_reg;
                mtag_reg <= t3_reg;
            end
        end
        if (state_reg == ST_RESP && out_free)
        begin
            out_item_reg.found         <= found_reg;
            out_item_reg.match_slot    <= 5'(slot_reg);
            out_item_reg.match_tag     <= mtag_reg;
            out_item_reg.add_ok        <= addok_reg;
            out_item_reg.entries_left  <= 6'(count_reg);
            out_item_reg.mouse_request <= req_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
endmodule
`default_nettype wire
